### hdl/srr_pkg.sv
// Shared types and codes for the serial receive ring with idle timeout.
package srr_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Classified command handed from the front end to the engine
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_TICK,
        CMD_READ,
        CMD_NOP
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        STS_ACCEPTED = 3'd0,
        STS_BYTE     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BUSY     = 3'd3,
        STS_EXPIRED  = 3'd4
    } t_status;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_POP
    } t_state;

    // One queued command
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic [6:0] limit;
        logic       use_term;
        logic [7:0] term;
    } t_cmd_item;

    // One result item
    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        logic       terminator_seen;
        logic       end_of_run;
        logic [6:0] run_count;
        logic [7:0] unread_left;
        logic [7:0] newest_byte;
        logic       newest_valid;
    } t_result;

endpackage

### hdl/srr_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
module srr_front
    import srr_pkg::*;
#(
    parameter int MAX_RUN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_data,
    input  logic [6:0] i_max_length,
    input  logic       i_use_terminator,
    input  logic [7:0] i_terminator,
    output logic       o_q_valid,
    output t_cmd_item  o_q_item,
    input  logic       i_q_pop
);

    localparam logic [6:0] MAX_LIM = 7'(MAX_RUN);

    t_cmd_item  w_item;
    t_cmd_item  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_push;

    // Classify the request and clamp the run length
    always_comb begin
        w_item.data     = i_rx_data;
        w_item.use_term = i_use_terminator;
        w_item.term     = i_terminator;
        unique case (i_req_type)
            REQ_BYTE: w_item.cmd = CMD_BYTE;
            REQ_TICK: w_item.cmd = CMD_TICK;
            REQ_READ: w_item.cmd = CMD_READ;
            default:  w_item.cmd = CMD_NOP;
        endcase
        if (i_max_length == 7'd0) begin
            w_item.limit = 7'd1;
        end else if (i_max_length > MAX_LIM) begin
            w_item.limit = MAX_LIM;
        end else begin
            w_item.limit = i_max_length;
        end
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = w_push  ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the item in the queue slot
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

### hdl/srr_engine.sv
// Back end: ring memory, idle countdown, read-run sequencer and result register.
module srr_engine
    import srr_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_timeout_reload,
    input  logic        i_q_valid,
    input  t_cmd_item   i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    localparam int         CW      = $clog2(RING_DEPTH);
    localparam logic [CW-1:0] CNT_MAX = CW'(RING_DEPTH - 1);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(RING_DEPTH);

    logic [7:0]    mem [RING_DEPTH];
    logic [7:0]    r_rdata;
    logic          w_mem_we;
    logic [CW:0]   w_addr_sum;
    logic [CW-1:0] w_rd_addr;

    t_state        r_state,  n_state;
    logic [CW-1:0] r_wp,     n_wp;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic [15:0]   r_cd,     n_cd;
    logic [7:0]    r_newest, n_newest;
    logic [6:0]    r_run,    n_run;
    logic [6:0]    r_limit,  n_limit;
    logic          r_uterm,  n_uterm;
    logic [7:0]    r_term,   n_term;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,    n_out;

    logic          w_load;
    logic          e_emit;
    t_status       e_status;
    logic [7:0]    e_data;
    logic          e_term;
    logic          e_eor;
    logic [6:0]    e_run;
    logic          w_is_term;
    logic [6:0]    w_run_next;
    logic          w_last;
    logic [15:0]   w_cd_dec;
    logic [CW+7:0] w_cnt_ext;

    // Oldest unread entry: write pointer minus unread count, modulo depth
    always_comb begin
        w_addr_sum = {1'b0, r_wp} + DEPTH_W - {1'b0, r_cnt};
        if (w_addr_sum >= DEPTH_W) begin
            w_addr_sum = w_addr_sum - DEPTH_W;
        end
        w_rd_addr = w_addr_sum[CW-1:0];
    end

    // Ring memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_wp] <= i_q_item.data;
        end
        r_rdata <= mem[w_rd_addr];
    end

    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_is_term  = r_uterm && (r_rdata == r_term);
    assign w_run_next = w_is_term ? r_run : r_run + 7'd1;
    assign w_last     = w_is_term || (w_run_next >= r_limit) || (r_cnt == CW'(1));
    assign w_cd_dec   = r_cd - 16'd1;

    // Sequence commands and build results
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_cd        = r_cd;
        n_newest    = r_newest;
        n_run       = r_run;
        n_limit     = r_limit;
        n_uterm     = r_uterm;
        n_term      = r_term;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        e_emit      = 1'b0;
        e_status    = STS_ACCEPTED;
        e_data      = 8'd0;
        e_term      = 1'b0;
        e_eor       = 1'b1;
        e_run       = 7'd0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_load && i_q_valid) begin
                    o_q_pop = 1'b1;
                    e_emit  = 1'b1;
                    case (i_q_item.cmd)
                        CMD_BYTE: begin
                            w_mem_we = 1'b1;
                            n_wp     = (r_wp == CNT_MAX) ? '0 : r_wp + CW'(1);
                            n_cnt    = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CW'(1);
                            n_cd     = i_timeout_reload;
                            n_newest = i_q_item.data;
                        end
                        CMD_TICK: begin
                            if (r_cd != 16'd0) begin
                                n_cd = w_cd_dec;
                                if (w_cd_dec == 16'd0) begin
                                    e_status = STS_EXPIRED;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (r_cd != 16'd0) begin
                                e_status = STS_BUSY;
                            end else if (r_cnt == '0) begin
                                e_status = STS_EMPTY;
                            end else begin
                                // start a run; the oldest byte is being read now
                                e_emit  = 1'b0;
                                n_run   = 7'd0;
                                n_limit = i_q_item.limit;
                                n_uterm = i_q_item.use_term;
                                n_term  = i_q_item.term;
                                n_state = ST_POP;
                            end
                        end
                        default: begin
                            e_status = STS_ACCEPTED;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_POP;
            end
            ST_POP: begin
                if (w_load) begin
                    e_emit   = 1'b1;
                    e_status = STS_BYTE;
                    e_data   = r_rdata;
                    e_term   = w_is_term;
                    e_eor    = w_last;
                    e_run    = w_run_next;
                    n_run    = w_run_next;
                    n_cnt    = r_cnt - CW'(1);
                    n_state  = w_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the result register from the updated state
        w_cnt_ext = (CW + 8)'(n_cnt);
        if (e_emit) begin
            n_out_valid           = 1'b1;
            n_out.status          = e_status;
            n_out.data_byte       = e_data;
            n_out.terminator_seen = e_term;
            n_out.end_of_run      = e_eor;
            n_out.run_count       = e_run;
            n_out.unread_left     = w_cnt_ext[7:0];
            n_out.newest_valid    = (n_cnt != '0);
            n_out.newest_byte     = (n_cnt != '0) ? n_newest : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_cd        <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_cd        <= n_cd;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_run    <= n_run;
        r_limit  <= n_limit;
        r_uterm  <= n_uterm;
        r_term   <= n_term;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### hdl/serial_rx_ring_with_idle_timeout.sv
// A received byte, tick or refused read is queued, then loaded into the result register.
// Throughput: one such item per cycle outside read runs and receiver stalls, set by the
// two-entry queue and the result register. Each byte of a read run comes from the registered
// read port of the ring memory, a fetch state between bytes; the queue accepts meanwhile.
// Reset (synchronous, active low) clears pointers, unread count, countdown, queue and
// timeout register; the ring memory is not cleared and no clearing pass is needed.
module serial_rx_ring_with_idle_timeout
    import srr_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    parameter int MAX_RUN    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_data,
    input  logic [6:0]  i_max_length,
    input  logic        i_use_terminator,
    input  logic [7:0]  i_terminator,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic        o_terminator_seen,
    output logic        o_end_of_run,
    output logic [6:0]  o_run_count,
    output logic [7:0]  o_unread_left,
    output logic [7:0]  o_newest_byte,
    output logic        o_newest_valid
);

    logic [15:0] r_timeout_reload;
    logic        w_q_valid;
    t_cmd_item   w_q_item;
    logic        w_q_pop;
    t_result     w_result;

    // Hold the timeout reload register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_reload <= 16'd0;
        end else if (i_cfg_we) begin
            r_timeout_reload <= i_cfg_data;
        end
    end

    srr_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_rx_data        (i_rx_data),
        .i_max_length     (i_max_length),
        .i_use_terminator (i_use_terminator),
        .i_terminator     (i_terminator),
        .o_q_valid        (w_q_valid),
        .o_q_item         (w_q_item),
        .i_q_pop          (w_q_pop)
    );

    srr_engine #(
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_timeout_reload (r_timeout_reload),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result         (w_result)
    );

    // Unpack the result item onto the ports
    assign o_status          = w_result.status;
    assign o_data_byte       = w_result.data_byte;
    assign o_terminator_seen = w_result.terminator_seen;
    assign o_end_of_run      = w_result.end_of_run;
    assign o_run_count       = w_result.run_count;
    assign o_unread_left     = w_result.unread_left;
    assign o_newest_byte     = w_result.newest_byte;
    assign o_newest_valid    = w_result.newest_valid;

endmodule

### dv/srr_checker.sv
// Checker for the serial receive ring: mirrors its state, predicts each result and compares.
module srr_checker
    import srr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_data,
    input  logic [6:0]  i_max_length,
    input  logic        i_use_terminator,
    input  logic [7:0]  i_terminator,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_data_byte,
    input  logic        i_terminator_seen,
    input  logic        i_end_of_run,
    input  logic [6:0]  i_run_count,
    input  logic [7:0]  i_unread_left,
    input  logic [7:0]  i_newest_byte,
    input  logic        i_newest_valid,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RING_SIZE   = 256;
    localparam logic [6:0] RUN_CAP     = 7'd64;
    localparam int         MAX_REPORTS = 10;

    // Mirrored ring state and timeout register
    logic [7:0]  ring_mem [0:RING_SIZE-1];
    logic [7:0]  wr_ptr;
    logic [7:0]  unread;
    logic [15:0] countdown;
    logic [15:0] reload;

    t_result     pending_results [$];
    int          fail_count = 0;
    int          results_checked = 0;

    assign o_fail_count      = fail_count;
    assign o_results_checked = results_checked;

    // Build one result from the current ring occupancy
    function automatic t_result ring_result(t_status sts, logic [7:0] data, logic hit,
                                            logic last, logic [6:0] count);
        t_result    r;
        logic [7:0] newest_idx;
        newest_idx        = wr_ptr - 8'd1;
        r.status          = sts;
        r.data_byte       = data;
        r.terminator_seen = hit;
        r.end_of_run      = last;
        r.run_count       = count;
        r.unread_left     = unread;
        r.newest_valid    = (unread != 8'd0);
        r.newest_byte     = (unread != 8'd0) ? ring_mem[newest_idx] : 8'd0;
        return r;
    endfunction

    // Count a failure, report only the first few
    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_result    got;
        t_result    want;
        string      diffs;
        logic [6:0] limit;
        logic [6:0] count;
        logic [7:0] oldest_idx;
        logic [7:0] popped;
        logic       hit;
        logic       last;
        t_status    tick_sts;

        if (!i_rst_n) begin
            wr_ptr    = 8'd0;
            unread    = 8'd0;
            countdown = 16'd0;
            reload    = 16'd0;
            pending_results.delete();
        end else begin
            // Compare a delivered result with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got.status          = t_status'(i_status);
                got.data_byte       = i_data_byte;
                got.terminator_seen = i_terminator_seen;
                got.end_of_run      = i_end_of_run;
                got.run_count       = i_run_count;
                got.unread_left     = i_unread_left;
                got.newest_byte     = i_newest_byte;
                got.newest_valid    = i_newest_valid;
                results_checked++;
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: status %0d data %02h eor %0b",
                                           i_status, i_data_byte, i_end_of_run));
                end else begin
                    want  = pending_results.pop_front();
                    diffs = "";
                    if (got.status !== want.status)
                        diffs = {diffs, $sformatf(" status %0d/%0d", want.status, i_status)};
                    if (got.data_byte !== want.data_byte)
                        diffs = {diffs, $sformatf(" data %02h/%02h", want.data_byte,
                                                  got.data_byte)};
                    if (got.terminator_seen !== want.terminator_seen)
                        diffs = {diffs, $sformatf(" term_seen %0b/%0b", want.terminator_seen,
                                                  got.terminator_seen)};
                    if (got.end_of_run !== want.end_of_run)
                        diffs = {diffs, $sformatf(" eor %0b/%0b", want.end_of_run,
                                                  got.end_of_run)};
                    if (got.run_count !== want.run_count)
                        diffs = {diffs, $sformatf(" run_count %0d/%0d", want.run_count,
                                                  got.run_count)};
                    if (got.unread_left !== want.unread_left)
                        diffs = {diffs, $sformatf(" unread %0d/%0d", want.unread_left,
                                                  got.unread_left)};
                    if (got.newest_byte !== want.newest_byte)
                        diffs = {diffs, $sformatf(" newest %02h/%02h", want.newest_byte,
                                                  got.newest_byte)};
                    if (got.newest_valid !== want.newest_valid)
                        diffs = {diffs, $sformatf(" newest_valid %0b/%0b", want.newest_valid,
                                                  got.newest_valid)};
                    if (diffs != "") begin
                        note_failure($sformatf("result %0d (expected/actual):%s",
                                               results_checked, diffs));
                    end
                end
            end

            // Latch the timeout reload value
            if (i_cfg_we) begin
                reload = i_cfg_data;
            end

            // Advance the mirror by one accepted item and queue its results
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_BYTE: begin
                        countdown        = reload;
                        ring_mem[wr_ptr] = i_rx_data;
                        if (unread != 8'hFF) unread = unread + 8'd1;
                        wr_ptr = wr_ptr + 8'd1;
                        pending_results.push_back(ring_result(STS_ACCEPTED, 8'd0, 1'b0,
                                                              1'b1, 7'd0));
                    end
                    REQ_TICK: begin
                        tick_sts = STS_ACCEPTED;
                        if (countdown != 16'd0) begin
                            countdown = countdown - 16'd1;
                            if (countdown == 16'd0) tick_sts = STS_EXPIRED;
                        end
                        pending_results.push_back(ring_result(tick_sts, 8'd0, 1'b0,
                                                              1'b1, 7'd0));
                    end
                    REQ_READ: begin
                        if (countdown != 16'd0) begin
                            pending_results.push_back(ring_result(STS_BUSY, 8'd0, 1'b0,
                                                                  1'b1, 7'd0));
                        end else if (unread == 8'd0) begin
                            pending_results.push_back(ring_result(STS_EMPTY, 8'd0, 1'b0,
                                                                  1'b1, 7'd0));
                        end else begin
                            if (i_max_length == 7'd0) limit = 7'd1;
                            else if (i_max_length > RUN_CAP) limit = RUN_CAP;
                            else limit = i_max_length;
                            count = 7'd0;
                            last  = 1'b0;
                            // Pop oldest first until terminator, limit or empty ring
                            while (!last) begin
                                oldest_idx = wr_ptr - unread;
                                popped     = ring_mem[oldest_idx];
                                unread     = unread - 8'd1;
                                hit        = i_use_terminator && (popped == i_terminator);
                                if (!hit) count = count + 7'd1;
                                last = hit || (count >= limit) || (unread == 8'd0);
                                pending_results.push_back(ring_result(STS_BYTE, popped, hit,
                                                                      last, count));
                            end
                        end
                    end
                    default: begin
                        pending_results.push_back(ring_result(STS_ACCEPTED, 8'd0, 1'b0,
                                                              1'b1, 7'd0));
                    end
                endcase
            end
        end
        o_outstanding <= pending_results.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the serial receive ring: clock, reset, stimulus, receiver stalls, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srr_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         IDLE_SETTLE     = 8;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_data   = 16'd0;
    logic        in_valid   = 1'b0;
    logic [1:0]  req_type   = REQ_BYTE;
    logic [7:0]  rx_data    = 8'd0;
    logic [6:0]  max_length = 7'd1;
    logic        use_term   = 1'b0;
    logic [7:0]  term_byte  = 8'd0;
    logic        out_stall  = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        term_seen;
    logic        end_of_run;
    logic [6:0]  run_count;
    logic [7:0]  unread_left;
    logic [7:0]  newest_byte;
    logic        newest_valid;

    int          fail_count;
    int          outstanding;
    int          results_checked;

    // Sender bookkeeping
    logic [15:0] cur_reload = 16'd0;
    bit          tx_quiet   = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;
    int          items_sent = 0;
    int          n_bytes    = 0;
    int          n_ticks    = 0;
    int          n_reads    = 0;
    int          n_unknown  = 0;

    always #5 clk = ~clk;

    serial_rx_ring_with_idle_timeout dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_rx_data        (rx_data),
        .i_max_length     (max_length),
        .i_use_terminator (use_term),
        .i_terminator     (term_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_data_byte      (data_byte),
        .o_terminator_seen(term_seen),
        .o_end_of_run     (end_of_run),
        .o_run_count      (run_count),
        .o_unread_left    (unread_left),
        .o_newest_byte    (newest_byte),
        .o_newest_valid   (newest_valid)
    );

    srr_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_rx_data        (rx_data),
        .i_max_length     (max_length),
        .i_use_terminator (use_term),
        .i_terminator     (term_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_data_byte      (data_byte),
        .i_terminator_seen(term_seen),
        .i_end_of_run     (end_of_run),
        .i_run_count      (run_count),
        .i_unread_left    (unread_left),
        .i_newest_byte    (newest_byte),
        .i_newest_valid   (newest_valid),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_results_checked(results_checked)
    );

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(logic [1:0] req, logic [7:0] rx, logic [6:0] len,
                             logic ut, logic [7:0] tm);
        int gap;
        int pick;
        gap = 0;
        if (!tx_quiet) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90) gap = $urandom_range(6, 25);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        rx_data    <= rx;
        max_length <= len;
        use_term   <= ut;
        term_byte  <= tm;
        do @(posedge clk); while (in_stall);
        case (req)
            REQ_BYTE: n_bytes++;
            REQ_TICK: n_ticks++;
            REQ_READ: n_reads++;
            default:  n_unknown++;
        endcase
        if (req != REQ_UNKNOWN) items_sent++;
    endtask

    // Fields that a request ignores carry random values
    task automatic send_byte(logic [7:0] b);
        send_item(REQ_BYTE, b, 7'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_read(logic [6:0] len, logic ut, logic [7:0] tm);
        send_item(REQ_READ, 8'($urandom), len, ut, tm);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [15:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_reload = value;
    endtask

    // Mostly framed bursts (bytes, enough ticks, reads), the rest random noise
    task automatic random_traffic(int target);
        int         start;
        int         pick;
        int         nb;
        int         nt;
        int         len_pick;
        logic [7:0] b;
        logic [7:0] tm;
        logic [6:0] len;
        logic [7:0] burst_bytes [$];
        start = items_sent;
        while (items_sent - start < target) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 99);
            if (pick < 75) begin
                burst_bytes.delete();
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
                repeat (nb) begin
                    b = ($urandom_range(0, 3) == 0) ? 8'h0D : 8'($urandom);
                    burst_bytes.push_back(b);
                    send_byte(b);
                end
                // Run the idle countdown out, sometimes one short or a little over
                nt = int'(cur_reload);
                pick = $urandom_range(0, 9);
                if (pick == 0 && nt > 0) nt = nt - 1;
                else if (pick == 1) nt = nt + $urandom_range(1, 2);
                repeat (nt) send_tick();
                repeat ($urandom_range(1, 3)) begin
                    len_pick = $urandom_range(0, 99);
                    if (len_pick < 70) len = 7'($urandom_range(1, 12));
                    else if (len_pick < 80) len = 7'd0;
                    else if (len_pick < 90) len = 7'($urandom_range(64, 127));
                    else len = 7'($urandom_range(13, 63));
                    pick = $urandom_range(0, 2);
                    if (pick == 0) tm = burst_bytes[$urandom_range(0, burst_bytes.size() - 1)];
                    else if (pick == 1) tm = 8'h0D;
                    else tm = 8'($urandom);
                    send_read(len, 1'($urandom), tm);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
                              1'($urandom), 8'($urandom));
                end
            end
        end
        tx_quiet = 1'b0;
    endtask

    // Receiver stalls: short and long runs, idle-free stretches, one long hold-off
    initial begin : result_stall_gen
        int span;
        int pick;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    out_stall <= 1'b0;
                    span = $urandom_range(1, 6);
                end else if (pick < 80) begin
                    out_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else if (pick < 92) begin
                    out_stall <= 1'b0;
                    span = $urandom_range(20, 60);
                end else begin
                    out_stall <= 1'b1;
                    span = $urandom_range(8, 30);
                end
                repeat (span - 1) @(posedge clk);
            end
        end
    end

    // Abort a hung run
    initial begin : watchdog
        #30ms;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty ring, idle tick, unknown request with all-ones fields
        cfg_write(16'd0);
        send_read(7'd1, 1'b0, 8'd0);
        send_tick();
        send_item(REQ_UNKNOWN, 8'hFF, 7'h7F, 1'b1, 8'hFF);

        // Directed: zero length, terminator stop, limit hit in terminator mode,
        // terminator as first byte, oversized length
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0A);
        send_byte(8'h41);
        send_byte(8'h0A);
        send_byte(8'h42);
        send_read(7'd0, 1'b0, 8'h00);
        send_read(7'd2, 1'b1, 8'h0A);
        send_read(7'd1, 1'b1, 8'h0A);
        send_read(7'd64, 1'b1, 8'h0A);
        send_read(7'd127, 1'b0, 8'h00);
        send_read(7'd5, 1'b0, 8'h00);

        // Directed: busy while the countdown runs, expiry, idle tick after expiry
        cfg_write(16'd2);
        send_byte(8'h5A);
        send_read(7'd4, 1'b0, 8'h00);
        send_tick();
        send_read(7'd4, 1'b0, 8'h00);
        send_tick();
        send_tick();
        send_read(7'd64, 1'b1, 8'h5A);

        // Random traffic without timeout; the receiver holds off at the start
        cfg_write(16'd0);
        hold_req = 1'b1;
        random_traffic(40);

        // Random traffic with short timeouts
        cfg_write(16'($urandom_range(1, 4)));
        random_traffic(25);
        cfg_write(16'($urandom_range(5, 9)));
        random_traffic(25);

        // Overfill the ring so the unread count saturates, then drain it in full runs
        cfg_write(16'd0);
        repeat (260) send_byte(8'($urandom));
        repeat (4) send_read(7'd64, 1'b0, 8'h00);
        send_read(7'($urandom_range(64, 127)), 1'b0, 8'h00);

        // Largest timeout: reads stay refused while ticks run
        cfg_write(16'hFFFF);
        send_byte(8'h33);
        send_read(7'd8, 1'b0, 8'h00);
        repeat (3) send_tick();
        send_read(7'd8, 1'b1, 8'h33);
        send_byte(8'hCC);
        send_tick();

        wait_idle();
        $display("covered %0d items: %0d bytes, %0d ticks, %0d reads, %0d unknown requests",
                 items_sent, n_bytes, n_ticks, n_reads, n_unknown);
        $display("checked %0d results across timeout settings 0, 2, small random and 65535",
                 results_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/srr_pkg.sv
hdl/srr_front.sv
hdl/srr_engine.sv
hdl/serial_rx_ring_with_idle_timeout.sv
dv/srr_checker.sv
dv/tb.sv
